// ===== hdl/fpa_pkg.sv =====
// shared types and codes for the fixed-point alu
package fpa_pkg;

	localparam logic [3:0] OP_ADD = 4'd0;
	localparam logic [3:0] OP_SUB = 4'd1;
	localparam logic [3:0] OP_MUL = 4'd2;
	localparam logic [3:0] OP_DIV = 4'd3;
	localparam logic [3:0] OP_GT = 4'd4;
	localparam logic [3:0] OP_LT = 4'd5;
	localparam logic [3:0] OP_GE = 4'd6;
	localparam logic [3:0] OP_LE = 4'd7;
	localparam logic [3:0] OP_EQ = 4'd8;
	localparam logic [3:0] OP_NE = 4'd9;
	localparam logic [3:0] OP_MIN = 4'd10;
	localparam logic [3:0] OP_MAX = 4'd11;
	localparam logic [3:0] OP_INC = 4'd12;
	localparam logic [3:0] OP_DEC = 4'd13;
	localparam logic [3:0] OP_FROMINT = 4'd14;
	localparam logic [3:0] OP_TOINT = 4'd15;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_OVF = 2'd1;
	localparam logic [1:0] ST_DIV0 = 2'd2;

	typedef struct packed {
		logic [3:0] operation;
		logic signed [31:0] operand_a;
		logic signed [31:0] operand_b;
	} fpa_in_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic compare_true;
		logic [1:0] status;
	} fpa_out_t;

	// classified item carried from front to back
	typedef struct packed {
		logic [3:0] op;
		logic neg;
		logic [31:0] mag_a;
		logic [31:0] mag_b;
		logic signed [31:0] a;
		logic signed [31:0] b;
	} fpa_cls_t;

endpackage

// ===== hdl/fixed_point_alu.sv =====
// top level of the signed fixed-point alu
// Usage: drive operands and raise start for one cycle per beat; busy is
// never raised, so a new beat may be issued every clock cycle.
// Each beat yields one result on the result port, marked by done for one
// cycle. Numbers are Q24.8 with the default FRAC_BITS; results come back in
// issue order for all operations.
// Throughput is one beat per cycle, set by the fully pipelined divider of
// 32 + FRAC_BITS restoring stages and the two-stage multiplier.
// The front end registers and classifies each beat; the back end runs
// every beat through one shared pipeline and selects the result at its end.
// Reset clears all valid flags; beats in flight are dropped.
// The receiver cannot stall: results must be taken when done is high.
module fixed_point_alu #(
	parameter int FRAC_BITS = 8
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input fpa_pkg::fpa_in_t operands,
	output logic busy,
	output logic done,
	output fpa_pkg::fpa_out_t result
);
	import fpa_pkg::*;

	logic item_valid;
	fpa_cls_t item;

	// front end
	fpa_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .operands(operands),
		.busy(busy), .item_valid(item_valid), .item(item)
	);

	// back end
	fpa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .item_valid(item_valid), .item(item),
		.done(done), .result(result)
	);
endmodule

// ===== hdl/fpa_front.sv =====
// front end: accepts beats, classifies and queues them
module fpa_front (
	input logic clk,
	input logic arst_n,
	input logic start,
	input fpa_pkg::fpa_in_t operands,
	output logic busy,
	output logic item_valid,
	output fpa_pkg::fpa_cls_t item
);
	import fpa_pkg::*;

	fpa_cls_t cls;
	logic valid_q;
	fpa_cls_t item_q;

	// split operands into sign and magnitude
	always_comb begin
		cls.op = operands.operation;
		cls.a = operands.operand_a;
		cls.b = operands.operand_b;
		cls.mag_a = operands.operand_a[31] ? 32'(-operands.operand_a) : operands.operand_a;
		cls.mag_b = operands.operand_b[31] ? 32'(-operands.operand_b) : operands.operand_b;
		cls.neg = operands.operand_a[31] ^ operands.operand_b[31];
	end

	// one-entry queue, back end always drains it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			item_q <= cls;
		end
	end

	assign busy = 1'b0;
	assign item_valid = valid_q;
	assign item = item_q;
endmodule

// ===== hdl/fpa_back.sv =====
// back end: pipelined execution of all operations
module fpa_back #(
	parameter int FRAC_BITS = 8
) (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input fpa_pkg::fpa_cls_t item,
	output logic done,
	output fpa_pkg::fpa_out_t result
);
	import fpa_pkg::*;

	localparam int NW = 32 + FRAC_BITS;
	localparam int NST = NW;
	localparam logic [63:0] HALF = 64'd1 << (FRAC_BITS - 1);

	// stage 1: simple ops and 16x32 partial products
	logic v_s1;
	fpa_cls_t it_s1;
	fpa_out_t simple_s1;
	logic [47:0] pl_s1, ph_s1;

	fpa_out_t simple;
	logic signed [32:0] sum;
	logic signed [63:0] fi;
	always_comb begin
		simple = '0;
		sum = '0;
		fi = 64'(item.a) <<< FRAC_BITS;
		case (item.op)
			OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
				case (item.op)
					OP_ADD: sum = 33'(item.a) + 33'(item.b);
					OP_SUB: sum = 33'(item.a) - 33'(item.b);
					OP_INC: sum = 33'(item.a) + 33'sd1;
					default: sum = 33'(item.a) - 33'sd1;
				endcase
				if (sum[32] != sum[31]) begin
					simple.status = ST_OVF;
					simple.result_value = sum[32] ? 32'sh80000000 : 32'sh7fffffff;
				end else begin
					simple.result_value = sum[31:0];
				end
			end
			OP_GT: simple.compare_true = item.a > item.b;
			OP_LT: simple.compare_true = item.a < item.b;
			OP_GE: simple.compare_true = item.a >= item.b;
			OP_LE: simple.compare_true = item.a <= item.b;
			OP_EQ: simple.compare_true = item.a == item.b;
			OP_NE: simple.compare_true = item.a != item.b;
			OP_MIN: simple.result_value = (item.a <= item.b) ? item.a : item.b;
			OP_MAX: simple.result_value = (item.a >= item.b) ? item.a : item.b;
			OP_FROMINT: begin
				if (fi > 64'sh7fffffff || fi < -64'sh80000000) begin
					simple.status = ST_OVF;
					simple.result_value = item.a[31] ? 32'sh80000000 : 32'sh7fffffff;
				end else begin
					simple.result_value = fi[31:0];
				end
			end
			OP_TOINT: simple.result_value = item.a >>> FRAC_BITS;
			default: simple = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		it_s1 <= item;
		simple_s1 <= simple;
		pl_s1 <= 48'(item.mag_a[15:0]) * 48'(item.mag_b);
		ph_s1 <= 48'(item.mag_a[31:16]) * 48'(item.mag_b);
	end

	// stage 2: sum product, round and saturate
	logic v_s2;
	fpa_cls_t it_s2;
	fpa_out_t mul_s2;
	fpa_out_t simple_s2;
	logic [63:0] prod;
	logic [63:0] pm;
	fpa_out_t mulr;
	always_comb begin
		prod = 64'(pl_s1) + (64'(ph_s1) << 16);
		pm = (prod + HALF) >> FRAC_BITS;
		mulr = '0;
		if (prod == 64'd0 || !it_s1.neg) begin
			if (pm > 64'h7fffffff) begin
				mulr.status = ST_OVF;
				mulr.result_value = 32'sh7fffffff;
			end else begin
				mulr.result_value = pm[31:0];
			end
		end else begin
			if (pm > 64'h80000000) begin
				mulr.status = ST_OVF;
				mulr.result_value = 32'sh80000000;
			end else begin
				mulr.result_value = 32'(-pm);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		it_s2 <= it_s1;
		mul_s2 <= mulr;
		simple_s2 <= simple_s1;
	end

	// divider: one restoring step per stage, NST stages
	logic [NST:0] dv_q;
	logic [NW-1:0] dn_q [NST+1];
	logic [32:0] dr_q [NST+1];
	logic [NW-1:0] dq_q [NST+1];
	logic [31:0] dd_q [NST+1];
	fpa_cls_t di_q [NST+1];
	fpa_out_t ds_q [NST+1];
	fpa_out_t dm_q [NST+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_q <= '0;
		end else begin
			dv_q <= {dv_q[NST-1:0], v_s2};
		end
	end

	always_ff @(posedge clk) begin
		dn_q[0] <= NW'(it_s2.mag_a) << FRAC_BITS;
		dr_q[0] <= '0;
		dq_q[0] <= '0;
		dd_q[0] <= it_s2.mag_b;
		di_q[0] <= it_s2;
		ds_q[0] <= simple_s2;
		dm_q[0] <= mul_s2;
	end

	for (genvar g = 0; g < NST; g++) begin : g_div
		logic [32:0] trial;
		logic [33:0] diff;
		assign trial = {dr_q[g][31:0], dn_q[g][NW-1]};
		assign diff = 34'(trial) - 34'(dd_q[g]);
		always_ff @(posedge clk) begin
			dn_q[g+1] <= dn_q[g] << 1;
			dr_q[g+1] <= diff[33] ? trial : diff[32:0];
			dq_q[g+1] <= {dq_q[g][NW-2:0], ~diff[33]};
			dd_q[g+1] <= dd_q[g];
			di_q[g+1] <= di_q[g];
			ds_q[g+1] <= ds_q[g];
			dm_q[g+1] <= dm_q[g];
		end
	end

	// final select with divide rounding
	logic [NW:0] q;
	logic [33:0] rem2;
	fpa_cls_t fi_it;
	fpa_out_t res;
	always_comb begin
		fi_it = di_q[NST];
		rem2 = {dr_q[NST], 1'b0};
		q = (NW+1)'(dq_q[NST]) + ((rem2 >= 34'(dd_q[NST])) ? (NW+1)'(1) : '0);
		res = ds_q[NST];
		case (fi_it.op)
			OP_MUL: res = dm_q[NST];
			OP_DIV: begin
				res = '0;
				if (fi_it.b == 32'sd0) begin
					res.status = ST_DIV0;
					if (fi_it.a > 0) res.result_value = 32'sh7fffffff;
					else if (fi_it.a < 0) res.result_value = 32'sh80000000;
				end else if (!fi_it.neg) begin
					if (q > (NW+1)'(32'h7fffffff)) begin
						res.status = ST_OVF;
						res.result_value = 32'sh7fffffff;
					end else begin
						res.result_value = q[31:0];
					end
				end else begin
					if (q > (NW+1)'(32'h80000000)) begin
						res.status = ST_OVF;
						res.result_value = 32'sh80000000;
					end else begin
						res.result_value = 32'(-q);
					end
				end
			end
			default: res = ds_q[NST];
		endcase
	end

	assign done = dv_q[NST];
	assign result = res;
endmodule

// ===== tb/fixed_point_alu_tb.sv =====
// testbench for the fixed-point alu: directed table and random beats against a predictor
`timescale 1ns / 100ps

module fixed_point_alu_tb;
	import fpa_pkg::*;

	localparam int FRAC_BITS = 8;
	localparam int LATENCY = FRAC_BITS + 36;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RANDOM_BEATS = 1000;
	localparam logic signed [31:0] MAX32 = 32'sh7fffffff;
	localparam logic signed [31:0] MIN32 = 32'sh80000000;

	logic clk;
	logic arst_n;
	logic start;
	fpa_in_t operands;
	logic busy;
	logic done;
	fpa_out_t result;

	fpa_out_t pending_results[$];
	int error_count;
	int idle_cycles;
	bit timed_out;

	// one directed row: beat plus optional typed-in result
	typedef struct {
		fpa_in_t beat;
		bit has_fixed;
		fpa_out_t fixed;
	} row_t;

	row_t directed_rows[$];

	fixed_point_alu #(.FRAC_BITS(FRAC_BITS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.operands(operands),
		.busy(busy),
		.done(done),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// saturate a wide value to 32 bits
	function automatic logic signed [31:0] saturate(input logic signed [95:0] v,
			inout logic [1:0] st);
		if (v > 96'sd2147483647) begin
			st = ST_OVF;
			return MAX32;
		end
		if (v < -96'sd2147483648) begin
			st = ST_OVF;
			return MIN32;
		end
		return v[31:0];
	endfunction

	// exact fixed-point arithmetic with half-away rounding
	function automatic fpa_out_t alu_predict(input fpa_in_t beat);
		fpa_out_t r;
		logic signed [95:0] a, b, p, v;
		logic [95:0] m, n, d, q, rem;
		logic [1:0] st;
		a = beat.operand_a;
		b = beat.operand_b;
		st = ST_OK;
		r.result_value = '0;
		r.compare_true = 1'b0;
		case (beat.operation)
			OP_ADD: r.result_value = saturate(a + b, st);
			OP_SUB: r.result_value = saturate(a - b, st);
			OP_MUL: begin
				p = a * b;
				m = p < 0 ? -p : p;
				m = (m + (96'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
				v = p < 0 ? -$signed(m) : $signed(m);
				r.result_value = saturate(v, st);
			end
			OP_DIV: begin
				if (b == 0) begin
					st = ST_DIV0;
					r.result_value = a > 0 ? MAX32 : (a < 0 ? MIN32 : 32'sd0);
				end else begin
					n = (a < 0 ? -a : a) << FRAC_BITS;
					d = b < 0 ? -b : b;
					q = n / d;
					rem = n % d;
					if (2 * rem >= d) q = q + 1;
					v = ((a < 0) != (b < 0)) ? -$signed(q) : $signed(q);
					r.result_value = saturate(v, st);
				end
			end
			OP_GT: r.compare_true = a > b;
			OP_LT: r.compare_true = a < b;
			OP_GE: r.compare_true = a >= b;
			OP_LE: r.compare_true = a <= b;
			OP_EQ: r.compare_true = a == b;
			OP_NE: r.compare_true = a != b;
			OP_MIN: r.result_value = (a <= b) ? beat.operand_a : beat.operand_b;
			OP_MAX: r.result_value = (a >= b) ? beat.operand_a : beat.operand_b;
			OP_INC: r.result_value = saturate(a + 1, st);
			OP_DEC: r.result_value = saturate(a - 1, st);
			OP_FROMINT: r.result_value = saturate(a <<< FRAC_BITS, st);
			default: r.result_value = beat.operand_a >>> FRAC_BITS;
		endcase
		r.status = st;
		return r;
	endfunction

	function automatic fpa_in_t make_beat(input logic [3:0] op,
			input logic signed [31:0] a, input logic signed [31:0] b);
		fpa_in_t t;
		t.operation = op;
		t.operand_a = a;
		t.operand_b = b;
		return t;
	endfunction

	task automatic add_row(input logic [3:0] op, input logic signed [31:0] a,
			input logic signed [31:0] b, input bit has_fixed,
			input logic signed [31:0] rv, input logic ct, input logic [1:0] st);
		row_t row;
		row.beat = make_beat(op, a, b);
		row.has_fixed = has_fixed;
		row.fixed.result_value = rv;
		row.fixed.compare_true = ct;
		row.fixed.status = st;
		directed_rows.push_back(row);
	endtask

	// operand biased toward extremes and small values
	function automatic logic signed [31:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return MAX32;
			1: return MIN32;
			2: return 32'sd0;
			3: return $signed(32'($urandom_range(0, 4096))) - 32'sd2048;
			4: return $signed(32'($urandom_range(0, 65535)) << 8) - 32'sh00800000;
			5: return MAX32 - $signed(32'($urandom_range(0, 3)));
			6: return MIN32 + $signed(32'($urandom_range(0, 3)));
			default: return $signed($urandom());
		endcase
	endfunction

	// idle cycles with start low, none for a back-to-back beat
	task automatic random_gap();
		int gap;
		case ($urandom_range(0, 19))
			0: gap = $urandom_range(20, 80);
			1, 2, 3, 4, 5, 6, 7: gap = $urandom_range(1, 3);
			default: gap = 0;
		endcase
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// issue one beat and hold it until accepted
	task automatic send_beat(input fpa_in_t beat);
		operands <= beat;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_results.push_back(alu_predict(beat));
		@(negedge clk);
	endtask

	// result checker against the oldest expectation
	always @(posedge clk) begin
		fpa_out_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result %h", $time, result);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (result.result_value !== want.result_value) begin
					$display("%0t: result_value expected %h actual %h", $time,
						want.result_value, result.result_value);
					error_count++;
				end
				if (result.compare_true !== want.compare_true) begin
					$display("%0t: compare_true expected %b actual %b", $time,
						want.compare_true, result.compare_true);
					error_count++;
				end
				if (result.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time,
						want.status, result.status);
					error_count++;
				end
			end
		end
	end

	// watchdog on cycles with no beat accepted either way
	always @(posedge clk) begin
		if ((start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		fpa_out_t want;
		int tail;
		arst_n = 1'b0;
		start = 1'b0;
		operands = '0;
		error_count = 0;
		idle_cycles = 0;
		timed_out = 1'b0;

		// directed table: extremes, every operation, special cases
		add_row(OP_ADD, MAX32, 32'sd1, 1, MAX32, 0, ST_OVF);
		add_row(OP_ADD, MIN32, -32'sd1, 1, MIN32, 0, ST_OVF);
		add_row(OP_SUB, MIN32, 32'sd1, 1, MIN32, 0, ST_OVF);
		add_row(OP_SUB, 32'sd0, MIN32, 1, MAX32, 0, ST_OVF);
		add_row(OP_MUL, MAX32, MAX32, 1, MAX32, 0, ST_OVF);
		add_row(OP_MUL, 32'sd384, 32'sd128, 0, 0, 0, ST_OK);
		add_row(OP_MUL, -32'sd384, 32'sd128, 0, 0, 0, ST_OK);
		add_row(OP_MUL, MIN32, MIN32, 1, MAX32, 0, ST_OVF);
		add_row(OP_DIV, 32'sd5, 32'sd0, 1, MAX32, 0, ST_DIV0);
		add_row(OP_DIV, -32'sd5, 32'sd0, 1, MIN32, 0, ST_DIV0);
		add_row(OP_DIV, 32'sd0, 32'sd0, 1, 32'sd0, 0, ST_DIV0);
		add_row(OP_DIV, 32'sd1, 32'sd512, 0, 0, 0, ST_OK);
		add_row(OP_DIV, MIN32, 32'sd1, 1, MIN32, 0, ST_OVF);
		add_row(OP_DIV, -32'sd256, 32'sd768, 0, 0, 0, ST_OK);
		add_row(OP_GT, MAX32, MIN32, 1, 32'sd0, 1, ST_OK);
		add_row(OP_LT, MAX32, MIN32, 1, 32'sd0, 0, ST_OK);
		add_row(OP_GE, 32'sd7, 32'sd7, 1, 32'sd0, 1, ST_OK);
		add_row(OP_LE, 32'sd8, 32'sd7, 1, 32'sd0, 0, ST_OK);
		add_row(OP_EQ, MIN32, MIN32, 1, 32'sd0, 1, ST_OK);
		add_row(OP_NE, MIN32, MIN32, 1, 32'sd0, 0, ST_OK);
		add_row(OP_MIN, MAX32, MIN32, 1, MIN32, 0, ST_OK);
		add_row(OP_MAX, MAX32, MIN32, 1, MAX32, 0, ST_OK);
		add_row(OP_INC, MAX32, 32'sd0, 1, MAX32, 0, ST_OVF);
		add_row(OP_DEC, MIN32, 32'sd0, 1, MIN32, 0, ST_OVF);
		add_row(OP_FROMINT, 32'sh00800000, 32'sd0, 1, MAX32, 0, ST_OVF);
		add_row(OP_TOINT, -32'sd1, MAX32, 1, -32'sd1, 0, ST_OK);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].has_fixed) begin
				want = alu_predict(directed_rows[i].beat);
				if (want !== directed_rows[i].fixed) begin
					$display("%0t: table row %0d expected %h predictor %h", $time, i,
						directed_rows[i].fixed, want);
					error_count++;
				end
			end
			send_beat(directed_rows[i].beat);
			if (i % 5 == 4) random_gap();
		end

		// random beats with bursts and gaps
		for (int i = 0; i < RANDOM_BEATS; i++) begin
			send_beat(make_beat(4'($urandom_range(0, 15)), pick_operand(), pick_operand()));
			random_gap();
		end
		start <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		tail = 0;
		while (tail < LATENCY + 10) begin
			@(posedge clk);
			tail++;
		end
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
